// ===== hw/rtl/touch_tap_swipe_classifier_top_assert.svh =====
// Assertion macros for the touch classifier.
`ifndef TOUCH_TAP_SWIPE_CLASSIFIER_TOP_ASSERT_SVH
`define TOUCH_TAP_SWIPE_CLASSIFIER_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define TTSC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("touch classifier check failed");
// next-cycle implication
`define TTSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("touch classifier check failed");
`else
`define TTSC_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define TTSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== hw/rtl/ttsc_pkg.sv =====
package ttsc_pkg;

    // result codes
    typedef enum logic [2:0] {
        EV_NONE  = 3'd0,
        EV_UP    = 3'd1,
        EV_DOWN  = 3'd2,
        EV_LEFT  = 3'd3,
        EV_RIGHT = 3'd4,
        EV_START = 3'd5,
        EV_MODE  = 3'd6
    } t_event;

    // register indexes
    localparam logic [2:0] CFG_SWIPE_MODE      = 3'd0;
    localparam logic [2:0] CFG_DEBOUNCE_MS     = 3'd1;
    localparam logic [2:0] CFG_SAMPLE_INTERVAL = 3'd2;
    localparam logic [2:0] CFG_SWIPE_MIN_RAW   = 3'd3;
    localparam logic [2:0] CFG_PAIR_TOLERANCE  = 3'd4;

    // register reset values
    localparam logic        RST_SWIPE_MODE      = 1'b0;
    localparam logic [15:0] RST_DEBOUNCE_MS     = 16'd80;
    localparam logic [15:0] RST_SAMPLE_INTERVAL = 16'd20;
    localparam logic [11:0] RST_SWIPE_MIN_RAW   = 12'd350;
    localparam logic [11:0] RST_PAIR_TOLERANCE  = 12'd80;

    // screen size defaults
    localparam int SCREEN_WIDTH_DEF  = 240;
    localparam int SCREEN_HEIGHT_DEF = 320;

    // calibration: sx = 235 - y*56/1000, sy = 304 - x*17/1000
    // divide by 1000 done as multiply by scaled reciprocal, exact for 12-bit input
    localparam logic [8:0]  CAL_SX_BASE = 9'd235;
    localparam logic [8:0]  CAL_SY_BASE = 9'd304;
    localparam logic [17:0] CAL_Y_MULT  = 18'd234885;   // 7 * ceil(2^22/125)
    localparam int          CAL_Y_SHIFT = 22;
    localparam logic [20:0] CAL_X_MULT  = 21'd1140853;  // 17 * ceil(2^26/1000)
    localparam int          CAL_X_SHIFT = 26;

    // button boxes
    localparam logic [8:0] BTN_SY_LO    = 9'd272;
    localparam logic [8:0] BTN_SY_HI    = 9'd320;
    localparam logic [8:0] BTN_START_HI = 9'd80;
    localparam logic [8:0] BTN_MODE_LO  = 9'd160;
    localparam logic [8:0] BTN_MODE_HI  = 9'd240;

    // tap mapping result
    typedef struct packed {
        logic   on_screen;
        t_event ev;
    } t_tap_res;

    function automatic logic [11:0] abs_diff(input logic [11:0] a, input logic [11:0] b);
        return (a >= b) ? (a - b) : (b - a);
    endfunction

endpackage

// ===== hw/rtl/touch_tap_swipe_classifier_top.sv =====
// Channel   Direction  Handshake          Payload
// scan in   input      i_valid / o_stall  i_action, i_now_ms, i_pen_down, i_x/y_first/second
// event out output     o_valid / i_stall  o_event_res
//
// One scan word per cycle sustained while i_stall is low; a word passes the input register, then the result register.
// The state update and classification are combinational between those two registers.
// Synchronous active-low reset clears config to defaults and tracking state to zero.
// A stall on the output holds the result; the input register then fills and o_stall rises.
module touch_tap_swipe_classifier_top #(
    parameter int SCREEN_WIDTH  = ttsc_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = ttsc_pkg::SCREEN_HEIGHT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config write port
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_wdata,
    // scan input
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_action,
    input  logic [31:0] i_now_ms,
    input  logic        i_pen_down,
    input  logic [11:0] i_x_first,
    input  logic [11:0] i_y_first,
    input  logic [11:0] i_x_second,
    input  logic [11:0] i_y_second,
    // event output
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_event_res
);

    // config registers
    logic        r_swipe_mode;
    logic [15:0] r_debounce_ms;
    logic [15:0] r_sample_interval;
    logic [11:0] r_swipe_min_raw;
    logic [11:0] r_pair_tolerance;

    // input register
    logic        r_in_valid;
    logic        r_in_action;
    logic [31:0] r_in_now;
    logic        r_in_pen;
    logic [11:0] r_in_x1, r_in_y1, r_in_x2, r_in_y2;

    // tracking state
    logic        r_tracking;
    logic [11:0] r_start_x, r_start_y, r_latest_x, r_latest_y;
    logic [31:0] r_event_time, r_sample_time;

    logic        n_tracking;
    logic [11:0] n_start_x, n_start_y, n_latest_x, n_latest_y;
    logic [31:0] n_event_time, n_sample_time;

    // result register
    logic             r_out_valid;
    ttsc_pkg::t_event r_out_ev;
    ttsc_pkg::t_event n_ev;

    logic out_load, step, in_load;
    logic [12:0] sum_x, sum_y;
    logic [11:0] avg_x, avg_y;
    logic        pair_ok, gates_ok;
    logic [11:0] trav_x, trav_y;
    ttsc_pkg::t_event swipe_ev;
    ttsc_pkg::t_tap_res tap_res;

    // handshake
    assign out_load = !r_out_valid || !i_stall;
    assign step     = r_in_valid && out_load;
    assign in_load  = !r_in_valid || out_load;
    assign o_stall  = !in_load;
    assign o_valid  = r_out_valid;
    assign o_event_res = r_out_ev;

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_swipe_mode      <= ttsc_pkg::RST_SWIPE_MODE;
            r_debounce_ms     <= ttsc_pkg::RST_DEBOUNCE_MS;
            r_sample_interval <= ttsc_pkg::RST_SAMPLE_INTERVAL;
            r_swipe_min_raw   <= ttsc_pkg::RST_SWIPE_MIN_RAW;
            r_pair_tolerance  <= ttsc_pkg::RST_PAIR_TOLERANCE;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                ttsc_pkg::CFG_SWIPE_MODE:      r_swipe_mode      <= i_cfg_wdata[0];
                ttsc_pkg::CFG_DEBOUNCE_MS:     r_debounce_ms     <= i_cfg_wdata;
                ttsc_pkg::CFG_SAMPLE_INTERVAL: r_sample_interval <= i_cfg_wdata;
                ttsc_pkg::CFG_SWIPE_MIN_RAW:   r_swipe_min_raw   <= i_cfg_wdata[11:0];
                ttsc_pkg::CFG_PAIR_TOLERANCE:  r_pair_tolerance  <= i_cfg_wdata[11:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_load) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_load && i_valid) begin
            r_in_action <= i_action;
            r_in_now    <= i_now_ms;
            r_in_pen    <= i_pen_down;
            r_in_x1     <= i_x_first;
            r_in_y1     <= i_y_first;
            r_in_x2     <= i_x_second;
            r_in_y2     <= i_y_second;
        end
    end

    // pair check and average
    assign sum_x   = {1'b0, r_in_x1} + {1'b0, r_in_x2};
    assign sum_y   = {1'b0, r_in_y1} + {1'b0, r_in_y2};
    assign avg_x   = sum_x[12:1];
    assign avg_y   = sum_y[12:1];
    assign pair_ok = (ttsc_pkg::abs_diff(r_in_x1, r_in_x2) <= r_pair_tolerance) &&
                     (ttsc_pkg::abs_diff(r_in_y1, r_in_y2) <= r_pair_tolerance);

    // debounce and sample interval, modulo 2^32
    assign gates_ok = ((r_in_now - r_event_time) >= {16'b0, r_debounce_ms}) &&
                      ((r_in_now - r_sample_time) >= {16'b0, r_sample_interval});

    // swipe direction from start to latest point
    assign trav_x = ttsc_pkg::abs_diff(r_start_x, r_latest_x);
    assign trav_y = ttsc_pkg::abs_diff(r_start_y, r_latest_y);

    always_comb begin
        if (trav_x < r_swipe_min_raw && trav_y < r_swipe_min_raw) begin
            swipe_ev = ttsc_pkg::EV_NONE;
        end else if (trav_y > trav_x) begin
            swipe_ev = (r_start_y > r_latest_y) ? ttsc_pkg::EV_LEFT : ttsc_pkg::EV_RIGHT;
        end else begin
            swipe_ev = (r_start_x > r_latest_x) ? ttsc_pkg::EV_DOWN : ttsc_pkg::EV_UP;
        end
    end

    ttsc_tap_map #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_tap_map (
        .i_avg_x (avg_x),
        .i_avg_y (avg_y),
        .o_res   (tap_res)
    );

    // next state and event for the word in the input register
    always_comb begin
        n_tracking    = r_tracking;
        n_start_x     = r_start_x;
        n_start_y     = r_start_y;
        n_latest_x    = r_latest_x;
        n_latest_y    = r_latest_y;
        n_event_time  = r_event_time;
        n_sample_time = r_sample_time;
        n_ev          = ttsc_pkg::EV_NONE;
        if (r_in_action) begin
            n_tracking    = 1'b0;
            n_start_x     = '0;
            n_start_y     = '0;
            n_latest_x    = '0;
            n_latest_y    = '0;
            n_event_time  = r_in_now;
            n_sample_time = r_in_now;
        end else if (!r_in_pen) begin
            // release
            if (r_tracking && r_swipe_mode) begin
                n_ev = swipe_ev;
                if (swipe_ev != ttsc_pkg::EV_NONE) begin
                    n_event_time = r_in_now;
                end
            end
            n_tracking = 1'b0;
        end else if (gates_ok) begin
            n_sample_time = r_in_now;
            if (pair_ok && (r_swipe_mode || tap_res.on_screen)) begin
                if (!r_tracking) begin
                    n_tracking = 1'b1;
                    n_start_x  = avg_x;
                    n_start_y  = avg_y;
                    if (!r_swipe_mode) begin
                        n_ev = tap_res.ev;
                        if (tap_res.ev != ttsc_pkg::EV_NONE) begin
                            n_event_time = r_in_now;
                        end
                    end
                end
                n_latest_x = avg_x;
                n_latest_y = avg_y;
            end
        end
    end

    // tracking state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tracking    <= 1'b0;
            r_start_x     <= '0;
            r_start_y     <= '0;
            r_latest_x    <= '0;
            r_latest_y    <= '0;
            r_event_time  <= '0;
            r_sample_time <= '0;
        end else if (step) begin
            r_tracking    <= n_tracking;
            r_start_x     <= n_start_x;
            r_start_y     <= n_start_y;
            r_latest_x    <= n_latest_x;
            r_latest_y    <= n_latest_y;
            r_event_time  <= n_event_time;
            r_sample_time <= n_sample_time;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_ev <= n_ev;
        end
    end

    // checks
`include "touch_tap_swipe_classifier_top_assert.svh"

    `TTSC_ASSERT_NEXT(a_swipe_ends_tracking, i_clk, i_rst_n, step && (n_ev == ttsc_pkg::EV_UP || n_ev == ttsc_pkg::EV_DOWN || n_ev == ttsc_pkg::EV_LEFT || n_ev == ttsc_pkg::EV_RIGHT), !r_tracking && r_event_time == $past(r_in_now))
    `TTSC_ASSERT_NEXT(a_button_starts_tracking, i_clk, i_rst_n, step && (n_ev == ttsc_pkg::EV_START || n_ev == ttsc_pkg::EV_MODE), r_tracking && r_event_time == $past(r_in_now))
    `TTSC_ASSERT_NEXT(a_clear_resets, i_clk, i_rst_n, step && r_in_action, !r_tracking && r_sample_time == $past(r_in_now) && r_out_ev == ttsc_pkg::EV_NONE)
    `TTSC_ASSERT_NOW(a_no_stall_when_empty, i_clk, i_rst_n, !r_in_valid, !o_stall)

endmodule

// ===== hw/rtl/ttsc_tap_map.sv =====
// Maps an averaged raw point to screen coordinates and hit-tests the buttons.
module ttsc_tap_map #(
    parameter int SCREEN_WIDTH  = ttsc_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = ttsc_pkg::SCREEN_HEIGHT_DEF
) (
    input  logic [11:0]        i_avg_x,
    input  logic [11:0]        i_avg_y,
    output ttsc_pkg::t_tap_res o_res
);

    logic [29:0] prod_y;
    logic [32:0] prod_x;
    logic [7:0]  quot_y;
    logic [6:0]  quot_x;
    logic [8:0]  sx;
    logic [8:0]  sy;

    // constant multiply replaces the divide by 1000
    assign prod_y = 30'(i_avg_y) * 30'(ttsc_pkg::CAL_Y_MULT);
    assign prod_x = 33'(i_avg_x) * 33'(ttsc_pkg::CAL_X_MULT);
    assign quot_y = prod_y[ttsc_pkg::CAL_Y_SHIFT +: 8];
    assign quot_x = prod_x[ttsc_pkg::CAL_X_SHIFT +: 7];

    // quotients stay below the bases, so sx and sy never go negative
    assign sx = ttsc_pkg::CAL_SX_BASE - {1'b0, quot_y};
    assign sy = ttsc_pkg::CAL_SY_BASE - {2'b0, quot_x};

    always_comb begin
        o_res.on_screen = ({4'b0, sx} < 13'(SCREEN_WIDTH)) &&
                          ({4'b0, sy} < 13'(SCREEN_HEIGHT));
        o_res.ev = ttsc_pkg::EV_NONE;
        if (sy >= ttsc_pkg::BTN_SY_LO && sy < ttsc_pkg::BTN_SY_HI) begin
            if (sx < ttsc_pkg::BTN_START_HI) begin
                o_res.ev = ttsc_pkg::EV_START;
            end else if (sx >= ttsc_pkg::BTN_MODE_LO && sx < ttsc_pkg::BTN_MODE_HI) begin
                o_res.ev = ttsc_pkg::EV_MODE;
            end
        end
    end

endmodule

// ===== tb/touch_board_pkg.sv =====
package touch_board_pkg;

    import ttsc_pkg::*;

    // action codes of a scan word
    localparam bit ACT_SCAN  = 1'b0;
    localparam bit ACT_CLEAR = 1'b1;

    typedef struct {
        bit        action;
        bit [31:0] now_ms;
        bit        pen_down;
        bit [11:0] x_first;
        bit [11:0] y_first;
        bit [11:0] x_second;
        bit [11:0] y_second;
    } scan_t;

    // Shadow of the classifier: register copy, tracking state and the queue of
    // events still to come out of the block.
    class touch_event_board;

        bit        swipe_on;
        bit [15:0] debounce_ms;
        bit [15:0] interval_ms;
        bit [11:0] min_travel;
        bit [11:0] pair_tol;

        bit        tracking;
        bit [11:0] start_x;
        bit [11:0] start_y;
        bit [11:0] last_x;
        bit [11:0] last_y;
        bit [31:0] event_ms;
        bit [31:0] sample_ms;

        t_event      event_q[$];
        int unsigned errors;

        function new();
            swipe_on    = RST_SWIPE_MODE;
            debounce_ms = RST_DEBOUNCE_MS;
            interval_ms = RST_SAMPLE_INTERVAL;
            min_travel  = RST_SWIPE_MIN_RAW;
            pair_tol    = RST_PAIR_TOLERANCE;
            tracking    = 1'b0;
            start_x     = '0;
            start_y     = '0;
            last_x      = '0;
            last_y      = '0;
            event_ms    = '0;
            sample_ms   = '0;
            errors      = 0;
        endfunction

        function void write_reg(bit [2:0] idx, bit [15:0] val);
            case (idx)
                CFG_SWIPE_MODE:      swipe_on    = val[0];
                CFG_DEBOUNCE_MS:     debounce_ms = val;
                CFG_SAMPLE_INTERVAL: interval_ms = val;
                CFG_SWIPE_MIN_RAW:   min_travel  = val[11:0];
                CFG_PAIR_TOLERANCE:  pair_tol    = val[11:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return event_q.size();
        endfunction

        // Accepted scan word: advance the shadow state, queue the event it yields.
        function void note_scan(scan_t s);
            t_event    ev;
            bit [31:0] since_ev;
            bit [31:0] since_smp;
            int        dh, dv, mag_h, mag_v;
            int        dx, dy, ax, ay, sx, sy;
            ev = EV_NONE;
            since_ev  = s.now_ms - event_ms;
            since_smp = s.now_ms - sample_ms;
            if (s.action == ACT_CLEAR) begin
                tracking  = 1'b0;
                start_x   = '0;
                start_y   = '0;
                last_x    = '0;
                last_y    = '0;
                event_ms  = s.now_ms;
                sample_ms = s.now_ms;
            end else if (!s.pen_down) begin
                // release: only a swipe in progress can report
                if (tracking && swipe_on) begin
                    dh    = int'(start_y) - int'(last_y);
                    dv    = int'(start_x) - int'(last_x);
                    mag_h = (dh < 0) ? -dh : dh;
                    mag_v = (dv < 0) ? -dv : dv;
                    if (mag_h < int'(min_travel) && mag_v < int'(min_travel))
                        ev = EV_NONE;
                    else if (mag_h > mag_v)
                        ev = (dh > 0) ? EV_LEFT : EV_RIGHT;
                    else
                        ev = (dv > 0) ? EV_DOWN : EV_UP;
                    if (ev != EV_NONE)
                        event_ms = s.now_ms;
                end
                tracking = 1'b0;
            end else if (since_ev >= 32'(debounce_ms) && since_smp >= 32'(interval_ms)) begin
                sample_ms = s.now_ms;
                dx = int'(s.x_first) - int'(s.x_second);
                dy = int'(s.y_first) - int'(s.y_second);
                if (dx < 0) dx = -dx;
                if (dy < 0) dy = -dy;
                if (dx <= int'(pair_tol) && dy <= int'(pair_tol)) begin
                    ax = (int'(s.x_first) + int'(s.x_second)) >> 1;
                    ay = (int'(s.y_first) + int'(s.y_second)) >> 1;
                    if (swipe_on) begin
                        if (!tracking) begin
                            tracking = 1'b1;
                            start_x  = 12'(ax);
                            start_y  = 12'(ay);
                        end
                        last_x = 12'(ax);
                        last_y = 12'(ay);
                    end else begin
                        // fixed panel calibration to screen pixels
                        sx = 235 - (ay * 56) / 1000;
                        sy = 304 - (ax * 17) / 1000;
                        if (sx >= 0 && sx < SCREEN_WIDTH_DEF && sy >= 0 && sy < SCREEN_HEIGHT_DEF) begin
                            if (!tracking) begin
                                tracking = 1'b1;
                                start_x  = 12'(ax);
                                start_y  = 12'(ay);
                                if (sy >= 272 && sy < 320) begin
                                    if (sx < 80)
                                        ev = EV_START;
                                    else if (sx >= 160 && sx < 240)
                                        ev = EV_MODE;
                                end
                                if (ev != EV_NONE)
                                    event_ms = s.now_ms;
                            end
                            last_x = 12'(ax);
                            last_y = 12'(ay);
                        end
                    end
                end
            end
            event_q.push_back(ev);
        endfunction

        // Accepted event word: compare with the oldest queued event.
        function void check_event(logic [2:0] got, longint unsigned at_ns);
            t_event want;
            if (event_q.size() == 0) begin
                errors++;
                $display("%0d ns: event word %0d with none expected", at_ns, got);
                return;
            end
            want = event_q.pop_front();
            if (got !== want) begin
                errors++;
                $display("%0d ns: event_res mismatch, expected %0d (%s), actual %0d",
                         at_ns, want, want.name(), got);
            end
        endfunction

    endclass

endpackage

// ===== tb/tb.sv =====
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import ttsc_pkg::*;
    import touch_board_pkg::*;

    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_ITEMS  = 115;
    localparam int SETTLE_TICKS = 4;

    typedef enum {RX_OPEN, RX_LIGHT, RX_HALF, RX_HEAVY} rx_mode_t;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic [2:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_wdata = '0;
    logic        i_valid     = 1'b0;
    logic        o_stall;
    logic        i_action    = 1'b0;
    logic [31:0] i_now_ms    = '0;
    logic        i_pen_down  = 1'b0;
    logic [11:0] i_x_first   = '0;
    logic [11:0] i_y_first   = '0;
    logic [11:0] i_x_second  = '0;
    logic [11:0] i_y_second  = '0;
    logic        o_valid;
    logic        i_stall     = 1'b0;
    logic [2:0]  o_event_res;

    touch_event_board board = new();

    bit [31:0]   scan_ms     = '0;
    int unsigned items_sent  = 0;
    int unsigned burst_left  = 0;
    bit          sender_gaps = 1'b1;
    int unsigned holds_asked = 0;

    touch_tap_swipe_classifier_top u_top (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // receiver: stall pattern in random stretches, plus requested long hold-offs
    initial begin : rx_stall
        rx_mode_t    rx_mode;
        int unsigned mode_left;
        int unsigned hold_left;
        int unsigned holds_seen;
        rx_mode    = RX_OPEN;
        mode_left  = 0;
        hold_left  = 0;
        holds_seen = 0;
        forever begin
            @(posedge i_clk);
            if (holds_seen != holds_asked) begin
                holds_seen = holds_asked;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                if (mode_left == 0) begin
                    rx_mode   = rx_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(10, 80);
                end
                mode_left--;
                case (rx_mode)
                    RX_OPEN:  i_stall <= 1'b0;
                    RX_LIGHT: i_stall <= ($urandom_range(0, 3) == 0);
                    RX_HALF:  i_stall <= 1'($urandom_range(0, 1));
                    default:  i_stall <= ($urandom_range(0, 4) != 0);
                endcase
            end
        end
    end

    // event monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            board.check_event(o_event_res, $time);
    end

    // offer one scan word, hold it until taken, then maybe pause the sender
    task automatic send_word(scan_t s);
        i_valid    <= 1'b1;
        i_action   <= s.action;
        i_now_ms   <= s.now_ms;
        i_pen_down <= s.pen_down;
        i_x_first  <= s.x_first;
        i_y_first  <= s.y_first;
        i_x_second <= s.x_second;
        i_y_second <= s.y_second;
        do @(posedge i_clk); while (o_stall);
        board.note_scan(s);
        items_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else if (sender_gaps) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = $urandom_range(0, 30);
        end
    endtask

    task automatic scan_at(bit [31:0] dt, bit pen, bit [11:0] x1, bit [11:0] y1,
                           bit [11:0] x2, bit [11:0] y2);
        scan_t s;
        scan_ms    = scan_ms + dt;
        s.action   = ACT_SCAN;
        s.now_ms   = scan_ms;
        s.pen_down = pen;
        s.x_first  = x1;
        s.y_first  = y1;
        s.x_second = x2;
        s.y_second = y2;
        send_word(s);
    endtask

    // clear word; the remaining fields carry junk
    task automatic clear_at(bit [31:0] dt);
        scan_t s;
        scan_ms    = scan_ms + dt;
        s.action   = ACT_CLEAR;
        s.now_ms   = scan_ms;
        s.pen_down = 1'($urandom_range(0, 1));
        s.x_first  = 12'($urandom);
        s.y_first  = 12'($urandom);
        s.x_second = 12'($urandom);
        s.y_second = 12'($urandom);
        send_word(s);
    endtask

    // stop offering and wait for every queued event to come out
    task automatic settle();
        i_valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_TICKS) @(posedge i_clk);
    endtask

    task automatic load_config(bit mode, bit [15:0] deb, bit [15:0] ivl,
                               bit [11:0] min_raw, bit [11:0] tol);
        logic [15:0] vals[5];
        logic [2:0]  idxs[5];
        vals = '{16'(mode), deb, ivl, 16'(min_raw), 16'(tol)};
        idxs = '{CFG_SWIPE_MODE, CFG_DEBOUNCE_MS, CFG_SAMPLE_INTERVAL,
                 CFG_SWIPE_MIN_RAW, CFG_PAIR_TOLERANCE};
        settle();
        for (int k = 0; k < 5; k++) begin
            i_cfg_wr_en <= 1'b1;
            i_cfg_index <= idxs[k];
            i_cfg_wdata <= vals[k];
            @(posedge i_clk);
            board.write_reg(idxs[k], vals[k]);
        end
        i_cfg_wr_en <= 1'b0;
    endtask

    function automatic int clamp12(int v);
        return (v < 0) ? 0 : ((v > 4095) ? 4095 : v);
    endfunction

    function automatic bit [11:0] near(int p, int spread);
        return 12'(clamp12(p + int'($urandom_range(0, 2 * spread)) - spread));
    endfunction

    // one press from touch-down to release, with random content
    task automatic random_touch();
        int        n, px, py, vx, vy, gate, tol;
        bit [31:0] dt;
        bit [11:0] x1, y1, x2, y2;
        tol  = int'(board.pair_tol);
        gate = (board.debounce_ms > board.interval_ms) ? int'(board.debounce_ms)
                                                       : int'(board.interval_ms);
        // aim at the button boxes often
        case ($urandom_range(0, 3))
            0: begin px = $urandom_range(0, 1900); py = $urandom_range(2790, 4095); end
            1: begin px = $urandom_range(0, 1900); py = $urandom_range(0, 1350); end
            default: begin px = $urandom_range(0, 4095); py = $urandom_range(0, 4095); end
        endcase
        vx = int'($urandom_range(0, 5000)) - 2500;
        vy = int'($urandom_range(0, 5000)) - 2500;
        n  = $urandom_range(1, 6);
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 7) == 0)
                dt = $urandom_range(0, gate);
            else
                dt = gate + $urandom_range(0, 40);
            if ($urandom_range(0, 9) == 0) begin
                scan_at(dt, 1'b1, 12'($urandom), 12'($urandom), 12'($urandom),
                        12'($urandom));
            end else begin
                x1 = near(px, tol / 2);
                y1 = near(py, tol / 2);
                x2 = near(int'(x1), tol);
                y2 = near(int'(y1), tol);
                scan_at(dt, 1'b1, x1, y1, x2, y2);
            end
            px = clamp12(px + vx / n);
            py = clamp12(py + vy / n);
        end
        scan_at($urandom_range(0, 60), 1'b0, 12'($urandom), 12'($urandom), 12'($urandom),
                12'($urandom));
    endtask

    task automatic random_noise();
        int px;
        px = $urandom_range(0, 4095);
        case ($urandom_range(0, 4))
            0: clear_at($urandom_range(0, 500));
            1: scan_at($urandom, 1'($urandom_range(0, 1)), 12'($urandom), 12'($urandom),
                       12'($urandom), 12'($urandom));
            2: scan_at($urandom_range(0, 200), 1'b1, 12'($urandom), 12'($urandom),
                       12'($urandom), 12'($urandom));
            3: scan_at($urandom_range(0, 200), 1'b0, 12'($urandom), 12'($urandom),
                       12'($urandom), 12'($urandom));
            default: scan_at($urandom_range(0, 200), 1'b1, near(px, 20), near(px, 20),
                             near(px, 20), near(px, 20));
        endcase
    endtask

    task automatic run_phase(int unsigned n, bit gaps);
        int unsigned target;
        target      = items_sent + n;
        sender_gaps = gaps;
        while (items_sent < target) begin
            if ($urandom_range(0, 4) != 0)
                random_touch();
            else
                random_noise();
        end
    endtask

    initial begin : stimulus
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // tap mode at reset values
        scan_at(0,   1'b1, 1000, 3000, 1000, 3000);  // debounce not met: gated
        scan_at(100, 1'b1, 1000, 3000, 1010, 2990);  // start button
        scan_at(30,  1'b1, 1200, 3100, 1200, 3100);  // debounce not met: gated
        scan_at(10,  1'b0, 0, 0, 0, 0);              // release
        scan_at(200, 1'b1, 500, 1000, 500, 1000);    // mode button
        scan_at(30,  1'b1, 0, 4095, 4095, 0);        // samples disagree, but debounce not met: gated
        scan_at(5,   1'b1, 4095, 0, 4095, 0);        // inside debounce time: gated
        scan_at(30,  1'b1, 4095, 0, 4095, 0);        // still tracking
        scan_at(10,  1'b0, 4095, 4095, 4095, 4095);
        scan_ms = 32'hFFFF_FFF0;
        clear_at(0);
        scan_at(32'h50, 1'b1, 0, 0, 0, 0);           // gate across the time wrap

        // swipe mode entered while still tracking
        load_config(1'b1, RST_DEBOUNCE_MS, RST_SAMPLE_INTERVAL,
                    RST_SWIPE_MIN_RAW, RST_PAIR_TOLERANCE);
        scan_at(100, 1'b1, 2000, 2000, 2000, 2000);
        scan_at(10,  1'b0, 0, 0, 0, 0);              // equal travel: vertical wins
        scan_at(100, 1'b1, 2000, 2000, 2000, 2000);
        scan_at(100, 1'b1, 2000, 2600, 2000, 2600);
        scan_at(10,  1'b0, 0, 0, 0, 0);              // right
        scan_at(100, 1'b1, 2000, 2600, 2000, 2600);
        scan_at(100, 1'b1, 2000, 2000, 2000, 2000);
        scan_at(10,  1'b0, 0, 0, 0, 0);              // left
        scan_at(100, 1'b1, 2500, 2000, 2500, 2000);
        scan_at(100, 1'b1, 2000, 2000, 2000, 2000);
        scan_at(10,  1'b0, 0, 0, 0, 0);              // down
        scan_at(100, 1'b1, 2000, 2000, 2000, 2000);
        scan_at(100, 1'b1, 2100, 2100, 2100, 2100);
        scan_at(10,  1'b0, 0, 0, 0, 0);              // too short

        // random phases over a spread of settings
        load_config(1'b1, 16'd0, 16'd0, 12'd0, 12'd0);
        run_phase(PHASE_ITEMS, 1'b1);
        load_config(1'b0, 16'hFFFF, 16'hFFFF, 12'hFFF, 12'hFFF);
        run_phase(PHASE_ITEMS, 1'b1);
        scan_ms = 32'hFFF0_0000;
        load_config(1'b1, 16'hFFFF, 16'hFFFF, 12'hFFF, 12'hFFF);
        run_phase(PHASE_ITEMS, 1'b1);
        // long receiver hold-off with the sender running flat out
        load_config(1'b0, RST_DEBOUNCE_MS, RST_SAMPLE_INTERVAL,
                    RST_SWIPE_MIN_RAW, RST_PAIR_TOLERANCE);
        holds_asked++;
        run_phase(PHASE_ITEMS, 1'b0);
        for (int ph = 0; ph < 4; ph++) begin
            load_config(1'($urandom_range(0, 1)), 16'($urandom_range(0, 300)),
                        16'($urandom_range(0, 100)), 12'($urandom_range(0, 1500)),
                        12'($urandom_range(0, 600)));
            if (ph == 1)
                scan_ms = $urandom;
            run_phase(PHASE_ITEMS, 1'b1);
        end

        settle();
        repeat (20) @(posedge i_clk);
        if (board.errors == 0 && board.pending() == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

    // watchdog
    initial begin : watchdog
        #5_000_000;
        $display("tb NOT OK");
        $finish;
    end

endmodule
